// File: sv/bctd_pkg.sv
`default_nettype none
package bctd_pkg;

  localparam int ADDR_W    = 3;
  localparam int TEXELS    = 16;
  localparam int IDX_W     = 4;
  localparam int TDATA_W   = 40;
  localparam logic [ADDR_W-1:0] ADDR_FMT = 3'd0;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2,
    FMT_RSVD = 2'd3
  } fmt_t;

  // channel 2 = red, 1 = green, 0 = blue
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    rgb_t        e0;
    rgb_t        e1;
    logic        four;
    logic        agt;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [63:0] ahalf;
    logic [31:0] cidx;
  } s1_t;

  typedef struct packed {
    rgb_t             e0;
    rgb_t             e1;
    logic             four;
    logic [2:0][9:0]  n2;
    logic [2:0][9:0]  n3;
    logic             agt;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic [5:0][10:0] an;
    logic [63:0]      ahalf;
    logic [31:0]      cidx;
  } s2_t;

  typedef struct packed {
    logic [3:0][2:0][7:0] cpal;
    logic                 clear3;
    logic [7:0][7:0]      apal;
    logic [63:0]          ahalf;
    logic [31:0]          cidx;
  } pal_t;

  function automatic rgb_t expand565(input logic [15:0] c);
    rgb_t e;
    e[2] = {c[15:11], c[15:13]};
    e[1] = {c[10:5], c[10:9]};
    e[0] = {c[4:0], c[4:2]};
    return e;
  endfunction

  // floor(x/3) for x < 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  // floor(x/7) for x < 1792
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  // floor(x/5) for x < 1280
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

endpackage
`default_nettype wire

// File: sv/bctd_endpoint.sv
`default_nettype none
module bctd_endpoint (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [63:0]     alpha_half,
  input  wire logic [63:0]     color_half,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bctd_pkg::s2_t        out_data
);

  logic          v1;
  logic          v2;
  bctd_pkg::s1_t s1;
  bctd_pkg::s2_t s2_next;
  logic          rdy1;
  logic          rdy2;

  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // expand endpoints, compare
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      s1.e0    <= bctd_pkg::expand565(color_half[15:0]);
      s1.e1    <= bctd_pkg::expand565(color_half[31:16]);
      s1.four  <= color_half[15:0] > color_half[31:16];
      s1.agt   <= alpha_half[7:0] > alpha_half[15:8];
      s1.a0    <= alpha_half[7:0];
      s1.a1    <= alpha_half[15:8];
      s1.ahalf <= alpha_half;
      s1.cidx  <= color_half[63:32];
    end
  end

  // form interpolation numerators
  always_comb begin
    s2_next.e0    = s1.e0;
    s2_next.e1    = s1.e1;
    s2_next.four  = s1.four;
    s2_next.agt   = s1.agt;
    s2_next.a0    = s1.a0;
    s2_next.a1    = s1.a1;
    s2_next.ahalf = s1.ahalf;
    s2_next.cidx  = s1.cidx;
    for (int ch = 0; ch < 3; ch++) begin
      if (s1.four) begin
        s2_next.n2[ch] = 10'({s1.e0[ch], 1'b0}) + 10'(s1.e1[ch]) + 10'd1;
        s2_next.n3[ch] = 10'(s1.e0[ch]) + 10'({s1.e1[ch], 1'b0}) + 10'd1;
      end else begin
        s2_next.n2[ch] = 10'(s1.e0[ch]) + 10'(s1.e1[ch]);
        s2_next.n3[ch] = 10'd0;
      end
    end
    for (int i = 1; i <= 6; i++) begin
      if (s1.agt) begin
        s2_next.an[i-1] = 11'(7 - i) * {3'b000, s1.a0} + 11'(i) * {3'b000, s1.a1} + 11'd3;
      end else if (i <= 4) begin
        s2_next.an[i-1] = 11'(5 - i) * {3'b000, s1.a0} + 11'(i) * {3'b000, s1.a1} + 11'd2;
      end else begin
        s2_next.an[i-1] = 11'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      out_data <= s2_next;
    end
  end

  assign out_valid = v2;

endmodule
`default_nettype wire

// File: sv/bctd_palette.sv
`default_nettype none
module bctd_palette (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bctd_pkg::fmt_t fmt,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire bctd_pkg::s2_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output bctd_pkg::pal_t      out_data
);

  logic           v;
  logic           rdy;
  bctd_pkg::pal_t pal_next;

  assign rdy      = !v || out_ready;
  assign in_ready = rdy;

  always_comb begin
    pal_next.cpal[0] = in_data.e0;
    pal_next.cpal[1] = in_data.e1;
    for (int ch = 0; ch < 3; ch++) begin
      if (in_data.four) begin
        pal_next.cpal[2][ch] = bctd_pkg::div3(in_data.n2[ch]);
        pal_next.cpal[3][ch] = bctd_pkg::div3(in_data.n3[ch]);
      end else begin
        pal_next.cpal[2][ch] = in_data.n2[ch][8:1];
        pal_next.cpal[3][ch] = 8'd0;
      end
    end
    pal_next.clear3  = !in_data.four && (fmt == bctd_pkg::FMT_DXT1);
    pal_next.apal[0] = in_data.a0;
    pal_next.apal[1] = in_data.a1;
    for (int i = 0; i < 6; i++) begin
      if (in_data.agt) begin
        pal_next.apal[i+2] = bctd_pkg::div7(in_data.an[i]);
      end else if (i < 4) begin
        pal_next.apal[i+2] = bctd_pkg::div5(in_data.an[i]);
      end else if (i == 4) begin
        pal_next.apal[i+2] = 8'h00;
      end else begin
        pal_next.apal[i+2] = 8'hFF;
      end
    end
    pal_next.ahalf = in_data.ahalf;
    pal_next.cidx  = in_data.cidx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (rdy) begin
      v <= in_valid;
    end
    if (rdy && in_valid) begin
      out_data <= pal_next;
    end
  end

  assign out_valid = v;

endmodule
`default_nettype wire

// File: sv/bctd_texel.sv
`default_nettype none
module bctd_texel (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bctd_pkg::fmt_t                fmt,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire bctd_pkg::pal_t                in_data,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [bctd_pkg::TDATA_W-1:0]       m_tdata,
  output logic                               m_tlast
);

  logic                       hold_v;
  bctd_pkg::pal_t             pal;
  logic [bctd_pkg::IDX_W-1:0] cnt;
  logic                       out_v;
  logic                       out_free;
  logic                       emit;
  logic                       blk_end;
  logic [1:0]                 ci;
  logic [3:0]                 nib;
  logic [2:0]                 ai;
  logic [5:0]                 abit;
  logic [7:0]                 alpha;

  assign out_free = !out_v || m_tready;
  assign emit     = hold_v && out_free;
  assign blk_end  = cnt == 4'(bctd_pkg::TEXELS - 1);
  assign in_ready = !hold_v || (emit && blk_end);

  assign ci   = pal.cidx[{cnt, 1'b0} +: 2];
  assign nib  = pal.ahalf[{cnt, 2'b00} +: 4];
  assign abit = 6'd16 + 6'(cnt) * 6'd3;
  assign ai   = pal.ahalf[abit +: 3];

  always_comb begin
    unique case (fmt)
      bctd_pkg::FMT_DXT1: alpha = (ci == 2'd3 && pal.clear3) ? 8'h00 : 8'hFF;
      bctd_pkg::FMT_DXT3: alpha = {nib, nib};
      bctd_pkg::FMT_DXT5: alpha = pal.apal[ai];
      default:            alpha = 8'hFF;
    endcase
  end

  // hold the block palette, step through its texels
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      cnt    <= '0;
    end else begin
      if (emit) begin
        cnt <= cnt + 4'd1;
      end
      if (in_ready) begin
        hold_v <= in_valid;
      end
    end
    if (in_ready && in_valid) begin
      pal <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_free) begin
      out_v <= emit;
    end
    if (emit) begin
      m_tdata <= {4'b0000, cnt, alpha, pal.cpal[ci][0], pal.cpal[ci][1], pal.cpal[ci][2]};
      m_tlast <= blk_end;
    end
  end

  assign m_tvalid = out_v;

endmodule
`default_nettype wire

// File: sv/bc_block_texture_decoder.sv
`default_nettype none
// S3TC (DXT1/DXT3/DXT5) block decoder. Each accepted input word is one 4x4 block and yields
// sixteen RGBA8 texel words in row-major order, tlast on the sixteenth. Blocks flow through
// endpoint expansion, numerator, palette and texel-select registers; the texel stage sends
// one texel per cycle unless m_tready stalls it, and loads the next block as it sends the
// last texel of the current one. Each texel word is registered once more at the output.
// block_format (byte address 0) must only change while idle.
module bc_block_texture_decoder (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [bctd_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [127:0]                       s_tdata,  // alpha_half, color_half
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [bctd_pkg::TDATA_W-1:0]            m_tdata,  // red, green, blue, alpha, texel_index
  output logic                                    m_tlast
);

  bctd_pkg::fmt_t fmt;
  logic           ep_valid;
  logic           ep_ready;
  bctd_pkg::s2_t  ep_data;
  logic           pl_valid;
  logic           pl_ready;
  bctd_pkg::pal_t pl_data;

  assign pready = 1'b1;
  assign prdata = (paddr == bctd_pkg::ADDR_FMT) ? {30'd0, fmt} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= bctd_pkg::FMT_DXT1;
    end else if (psel && penable && pwrite && pready && paddr == bctd_pkg::ADDR_FMT) begin
      fmt <= bctd_pkg::fmt_t'(pwdata[1:0]);
    end
  end

  bctd_endpoint u_endpoint (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .alpha_half (s_tdata[63:0]),
    .color_half (s_tdata[127:64]),
    .out_valid  (ep_valid),
    .out_ready  (ep_ready),
    .out_data   (ep_data)
  );

  bctd_palette u_palette (
    .clk       (clk),
    .rst       (rst),
    .fmt       (fmt),
    .in_valid  (ep_valid),
    .in_ready  (ep_ready),
    .in_data   (ep_data),
    .out_valid (pl_valid),
    .out_ready (pl_ready),
    .out_data  (pl_data)
  );

  bctd_texel u_texel (
    .clk      (clk),
    .rst      (rst),
    .fmt      (fmt),
    .in_valid (pl_valid),
    .in_ready (pl_ready),
    .in_data  (pl_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// File: sv/bctd_checker.sv
`default_nettype none
module bctd_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [bctd_pkg::TDATA_W-1:0] m_tdata,
  input wire logic                         m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[35:32] == 4'hF)))
    else $error("tlast does not match texel 15");

  a_next: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && m_tdata[35:32] == $past(m_tdata[35:32]) + 4'd1)
    else $error("texel sequence broken inside a block");

  a_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tdata[35:32] == 4'h0)
    else $error("block does not start at texel 0");

endmodule

bind bc_block_texture_decoder bctd_checker u_bctd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire

// File: tb/sv/tb.sv
`default_nettype none
module tb;

  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam int QUIET_CYCLES = 8;
  localparam int RANDOM_PHASES = 10;
  localparam int BLOCKS_PER_PHASE = 25;
  localparam logic [bctd_pkg::ADDR_W-1:0] ADDR_UNUSED = 3'd4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] texel_index;
    logic       last_texel;
  } texel_t;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [bctd_pkg::ADDR_W-1:0]   paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [127:0]                  s_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [bctd_pkg::TDATA_W-1:0]  m_tdata;
  logic                          m_tlast;

  bctd_pkg::fmt_t cur_fmt;
  texel_t texel_q[$];
  texel_t got_texel;
  int     err_cnt;
  int     mismatch_cnt;
  int     idle_cycles;
  bit     tx_idle;
  bit     rx_idle;
  bit     texel_taken;
  int     rx_gap;

  bc_block_texture_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void predict_texels(input logic [63:0] ah, input logic [63:0] ch);
    logic [15:0] c0;
    logic [15:0] c1;
    int unsigned cr[4];
    int unsigned cg[4];
    int unsigned cb[4];
    int unsigned ca[4];
    int unsigned apal[8];
    int unsigned a0;
    int unsigned a1;
    int unsigned ci;
    int unsigned av;
    texel_t t;
    c0 = ch[15:0];
    c1 = ch[31:16];
    cr[0] = {c0[15:11], c0[15:13]};
    cg[0] = {c0[10:5], c0[10:9]};
    cb[0] = {c0[4:0], c0[4:2]};
    cr[1] = {c1[15:11], c1[15:13]};
    cg[1] = {c1[10:5], c1[10:9]};
    cb[1] = {c1[4:0], c1[4:2]};
    ca[0] = 255;
    ca[1] = 255;
    ca[2] = 255;
    if (c0 > c1) begin
      cr[2] = (2 * cr[0] + cr[1] + 1) / 3;
      cg[2] = (2 * cg[0] + cg[1] + 1) / 3;
      cb[2] = (2 * cb[0] + cb[1] + 1) / 3;
      cr[3] = (cr[0] + 2 * cr[1] + 1) / 3;
      cg[3] = (cg[0] + 2 * cg[1] + 1) / 3;
      cb[3] = (cb[0] + 2 * cb[1] + 1) / 3;
      ca[3] = 255;
    end else begin
      cr[2] = (cr[0] + cr[1]) / 2;
      cg[2] = (cg[0] + cg[1]) / 2;
      cb[2] = (cb[0] + cb[1]) / 2;
      cr[3] = 0;
      cg[3] = 0;
      cb[3] = 0;
      ca[3] = (cur_fmt == bctd_pkg::FMT_DXT1) ? 0 : 255;
    end
    a0 = ah[7:0];
    a1 = ah[15:8];
    apal[0] = a0;
    apal[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i <= 6; i++) apal[i + 1] = ((7 - i) * a0 + i * a1 + 3) / 7;
    end else begin
      for (int i = 1; i <= 4; i++) apal[i + 1] = ((5 - i) * a0 + i * a1 + 2) / 5;
      apal[6] = 0;
      apal[7] = 255;
    end
    for (int k = 0; k < bctd_pkg::TEXELS; k++) begin
      ci = ch[32 + 2 * k +: 2];
      av = ca[ci];
      case (cur_fmt)
        bctd_pkg::FMT_DXT3: av = {ah[4 * k +: 4], ah[4 * k +: 4]};
        bctd_pkg::FMT_DXT5: av = apal[ah[16 + 3 * k +: 3]];
        default: ;
      endcase
      t.red         = 8'(cr[ci]);
      t.green       = 8'(cg[ci]);
      t.blue        = 8'(cb[ci]);
      t.alpha       = 8'(av);
      t.texel_index = 4'(k);
      t.last_texel  = (k == bctd_pkg::TEXELS - 1);
      texel_q.push_back(t);
    end
  endfunction

  function automatic void report_texel(input string what, input texel_t want,
                                       input texel_t got);
    err_cnt++;
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $write("%0t %s: exp r=%02h g=%02h b=%02h a=%02h idx=%0d last=%0b, ",
             $time, what, want.red, want.green, want.blue, want.alpha,
             want.texel_index, want.last_texel);
      $display("got r=%02h g=%02h b=%02h a=%02h idx=%0d last=%0b",
               got.red, got.green, got.blue, got.alpha, got.texel_index,
               got.last_texel);
    end
  endfunction

  function automatic void check_texel(input texel_t got);
    texel_t want;
    if (texel_q.size() == 0) begin
      want = '0;
      report_texel("unexpected texel", want, got);
    end else begin
      want = texel_q.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.alpha !== want.alpha || got.texel_index !== want.texel_index ||
          got.last_texel !== want.last_texel)
        report_texel("texel mismatch", want, got);
    end
  endfunction

  always @(posedge clk) begin
    texel_taken <= !rst && m_tvalid && m_tready;
    if (!rst && m_tvalid && m_tready) begin
      got_texel.red         = m_tdata[7:0];
      got_texel.green       = m_tdata[15:8];
      got_texel.blue        = m_tdata[23:16];
      got_texel.alpha       = m_tdata[31:24];
      got_texel.texel_index = m_tdata[35:32];
      got_texel.last_texel  = m_tlast;
      check_texel(got_texel);
    end
  end

  // Downstream backpressure: with rx_idle, tready stays low a random gap after each word.
  initial begin
    m_tready = 1'b0;
    rx_gap = 0;
    forever begin
      @(negedge clk);
      if (texel_taken) rx_gap = rx_idle ? $urandom_range(0, 15) : 0;
      if (rst) begin
        m_tready = 1'b0;
      end else if (rx_gap > 0) begin
        m_tready = 1'b0;
        rx_gap--;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("** bc_block_texture_decoder: FAILED **");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [bctd_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == bctd_pkg::ADDR_FMT) cur_fmt = bctd_pkg::fmt_t'(data[1:0]);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_format_reg();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = bctd_pkg::ADDR_FMT;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {30'd0, cur_fmt}) begin
      err_cnt++;
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("%0t format readback: exp %0d, got %0h", $time, cur_fmt, prdata);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_format(input bctd_pkg::fmt_t fmt);
    apb_write(bctd_pkg::ADDR_FMT, {30'd0, fmt});
    check_format_reg();
  endtask

  task automatic set_idle(input int mode);
    tx_idle = mode[0];
    rx_idle = mode[1];
  endtask

  task automatic send_block(input logic [63:0] ah, input logic [63:0] ch);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = {ch, ah};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_texels(ah, ch);
  endtask

  // Drop tvalid, wait for every texel, then let the pipe settle.
  task automatic wait_quiet();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (texel_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic send_directed(input int n);
    case (n)
      0: send_block(64'h0, 64'h0);
      1: send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      2: send_block({48'hFAC688FAC688, 8'h10, 8'hF0}, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
      3: send_block({48'hFAC688FAC688, 8'hF0, 8'h10}, {32'hE4E4E4E4, 16'hF81F, 16'h07E0});
      default: send_block(64'hFEDCBA98_76543210, {32'h1B1B1B1B, 16'h1234, 16'h1234});
    endcase
  endtask

  task automatic random_block(output logic [63:0] ah, output logic [63:0] ch);
    int kind;
    kind = $urandom_range(0, 7);
    ah = {$urandom, $urandom};
    ch = {$urandom, $urandom};
    case (kind)
      0: ch[31:16] = ch[15:0];
      1: ah[15:8] = ah[7:0];
      2: begin
        ch[31:16] = ch[15:0];
        ah[15:8] = ah[7:0];
      end
      default: ;
    endcase
  endtask

  task automatic test_reset_format();
    set_idle(0);
    check_format_reg();
    send_directed(2);
    send_directed(3);
    wait_quiet();
  endtask

  task automatic test_directed();
    bctd_pkg::fmt_t fmts[4];
    fmts = '{bctd_pkg::FMT_DXT1, bctd_pkg::FMT_DXT3, bctd_pkg::FMT_DXT5, bctd_pkg::FMT_RSVD};
    for (int f = 0; f < 4; f++) begin
      set_format(fmts[f]);
      set_idle(f);
      for (int n = 0; n < 5; n++) send_directed(n);
      wait_quiet();
    end
  endtask

  task automatic test_unmapped_write();
    set_format(bctd_pkg::FMT_DXT5);
    apb_write(ADDR_UNUSED, {30'd0, bctd_pkg::FMT_DXT1});
    set_idle(3);
    send_directed(3);
    wait_quiet();
    check_format_reg();
  endtask

  task automatic test_random();
    logic [63:0] ah;
    logic [63:0] ch;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_quiet();
      set_format(ph < 4 ? bctd_pkg::fmt_t'(ph) : bctd_pkg::fmt_t'($urandom_range(0, 3)));
      set_idle(ph == 0 ? 0 : $urandom_range(0, 3));
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        random_block(ah, ch);
        if ($urandom_range(0, 24) == 0) wait_quiet();
        send_block(ah, ch);
      end
    end
    wait_quiet();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cur_fmt = bctd_pkg::FMT_DXT1;
    err_cnt = 0;
    mismatch_cnt = 0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_format();
    test_directed();
    test_unmapped_write();
    test_random();
    repeat (2 * bctd_pkg::TEXELS) @(posedge clk);
    if (texel_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("** bc_block_texture_decoder: PASSED **");
    end else begin
      $display("** bc_block_texture_decoder: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
